[rtl/assert_macros.svh]
// Assertion macros for the RTL files that check themselves.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Checked on every rising clock edge while reset is released.
`define ASSERT_CLK(label, prop) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) \
    else $error("assertion failed");

// Checked on every rising clock edge, reset included.
`define ASSERT_ALWAYS(label, prop) \
  label: assert property (@(posedge clk_i) prop) \
    else $error("assertion failed");

`endif

[rtl/sst_pkg.sv]
// Package with the types, codes and constants of the steer/throttle frame decoder.
package sst_pkg;

  // Character codes used by the field parser.
  localparam logic [7:0] CharNewline = 8'd10;
  localparam logic [7:0] CharSpace   = 8'd32;
  localparam logic [7:0] CharTab     = 8'd9;
  localparam logic [7:0] CharCr      = 8'd13;
  localparam logic [7:0] CharPlus    = 8'd43;
  localparam logic [7:0] CharMinus   = 8'd45;
  localparam logic [7:0] CharZero    = 8'd48;
  localparam logic [7:0] CharNine    = 8'd57;

  // Frame layout: power field is bytes 0..2, steering field bytes 3..5.
  localparam logic [2:0] PosPowerLast = 3'd2;
  localparam logic [2:0] PosSteerLast = 3'd5;

  // Field limits after clamping.
  localparam logic [9:0] FieldMax  = 10'd100;
  localparam logic [6:0] FieldMid  = 7'd50;

  // Compare value anchors.
  localparam logic [7:0] SteerCenter  = 8'd146;
  localparam logic [7:0] ThrottleIdle = 8'd50;

  // Division by 100 is a multiply by 5243 and a shift by 19, and division by 10
  // a multiply by 6554 and a shift by 16; both are exact over the ranges here.
  // The slope is folded into the reciprocal so each path has one multiply.
  localparam int unsigned Recip100    = 5243;
  localparam int unsigned Shift100    = 19;
  localparam int unsigned Recip10     = 6554;
  localparam int unsigned Shift10     = 16;
  localparam logic [18:0] SteerUpK    = 19'(62 * Recip100);
  localparam logic [17:0] SteerDownK  = 18'(48 * Recip100);
  localparam logic [19:0] SteerDownC  = 20'(99 * Recip100);
  localparam logic [17:0] ThrottleK   = 18'(39 * Recip10);

  // Parser phase within one field.
  typedef enum logic [1:0] {
    PH_SKIP   = 2'd0,
    PH_SIGN   = 2'd1,
    PH_DIGITS = 2'd2,
    PH_DONE   = 2'd3
  } phase_e;

  // What the parser hands to the output side for the byte it is consuming.
  typedef struct packed {
    logic       emit;
    logic [6:0] steer;
    logic [6:0] power;
  } parse_t;

endpackage

[rtl/sst_parser.sv]
// Frame hunter and strtol-style field parser holding the frame state.
module sst_parser
  import sst_pkg::*;
(
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       advance_i,
  input  logic [7:0] byte_i,
  output parse_t     parse_o
);

  logic       in_frame_q, in_frame_d;
  logic [2:0] pos_q, pos_d;
  logic [9:0] value_q, value_d;
  logic       neg_q, neg_d;
  phase_e     phase_q, phase_d;
  logic [6:0] power_q;

  logic       is_digit;
  logic       is_space;
  logic [3:0] digit;
  logic [9:0] fed_value;
  logic       fed_neg;
  phase_e     fed_phase;
  logic [6:0] fed_clamped;

  // Character classes of the incoming byte.
  assign is_digit = (byte_i >= CharZero) && (byte_i <= CharNine);
  assign is_space = (byte_i == CharSpace) || ((byte_i >= CharTab) && (byte_i <= CharCr));
  assign digit    = 4'(byte_i - CharZero);

  // Field state after this byte is fed.
  always_comb begin
    fed_value = value_q;
    fed_neg   = neg_q;
    fed_phase = phase_q;
    case (phase_q)
      PH_SKIP: begin
        if (is_space) begin
          fed_phase = PH_SKIP;
        end else if ((byte_i == CharPlus) || (byte_i == CharMinus)) begin
          fed_neg   = (byte_i == CharMinus);
          fed_phase = PH_SIGN;
        end else if (is_digit) begin
          fed_value = {6'd0, digit};
          fed_phase = PH_DIGITS;
        end else begin
          fed_phase = PH_DONE;
        end
      end
      PH_SIGN, PH_DIGITS: begin
        if (is_digit) begin
          fed_value = 10'({value_q, 3'd0} + {value_q, 1'b0} + {10'd0, digit});
          fed_phase = PH_DIGITS;
        end else begin
          fed_phase = PH_DONE;
        end
      end
      default: begin
        fed_phase = PH_DONE;
      end
    endcase
  end

  // Clamp the fed field to 0..100; a minus sign always gives zero.
  always_comb begin
    if (fed_neg) begin
      fed_clamped = 7'd0;
    end else if (fed_value > FieldMax) begin
      fed_clamped = 7'(FieldMax);
    end else begin
      fed_clamped = fed_value[6:0];
    end
  end

  // Next frame state for a consumed byte.
  always_comb begin
    in_frame_d = in_frame_q;
    pos_d      = pos_q;
    value_d    = value_q;
    neg_d      = neg_q;
    phase_d    = phase_q;
    if (advance_i) begin
      if (!in_frame_q) begin
        if (byte_i == CharNewline) begin
          in_frame_d = 1'b1;
          pos_d      = 3'd0;
          value_d    = 10'd0;
          neg_d      = 1'b0;
          phase_d    = PH_SKIP;
        end
      end else if ((pos_q == PosPowerLast) || (pos_q >= PosSteerLast)) begin
        // End of a field: start the next one clean.
        in_frame_d = (pos_q == PosPowerLast);
        pos_d      = (pos_q == PosPowerLast) ? 3'(PosPowerLast + 3'd1) : 3'd0;
        value_d    = 10'd0;
        neg_d      = 1'b0;
        phase_d    = PH_SKIP;
      end else begin
        pos_d   = pos_q + 3'd1;
        value_d = fed_value;
        neg_d   = fed_neg;
        phase_d = fed_phase;
      end
    end
  end

  // Control state registers.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_frame_q <= 1'b0;
      pos_q      <= 3'd0;
      value_q    <= 10'd0;
      neg_q      <= 1'b0;
      phase_q    <= PH_SKIP;
    end else begin
      in_frame_q <= in_frame_d;
      pos_q      <= pos_d;
      value_q    <= value_d;
      neg_q      <= neg_d;
      phase_q    <= phase_d;
    end
  end

  // Power is captured at the last byte of the first field.
  always_ff @(posedge clk_i) begin
    if (advance_i && in_frame_q && (pos_q == PosPowerLast)) begin
      power_q <= fed_clamped;
    end
  end

  assign parse_o.emit  = in_frame_q && (pos_q >= PosSteerLast);
  assign parse_o.steer = fed_clamped;
  assign parse_o.power = power_q;

endmodule

[rtl/sst_mapper.sv]
// Maps clamped steering and power values to PWM compare values.
module sst_mapper
  import sst_pkg::*;
(
  input  parse_t     parse_i,
  output logic [7:0] steer_o,
  output logic [7:0] throttle_o
);

  logic        steer_up;
  logic [5:0]  d_up;
  logic [5:0]  d_down;
  logic [24:0] up_prod;
  logic [24:0] down_prod;
  logic [5:0]  up_step;
  logic [5:0]  down_step;
  logic        throttle_on;
  logic [5:0]  p_over;
  logic [23:0] thr_prod;
  logic [7:0]  thr_step;

  // Steering: left of center rounds down, right of center rounds the drop up.
  assign steer_up  = parse_i.steer < FieldMid;
  assign d_up      = 6'(FieldMid - parse_i.steer);
  assign d_down    = 6'(parse_i.steer - FieldMid);
  assign up_prod   = 25'(d_up * SteerUpK);
  assign down_prod = 25'(d_down * SteerDownK) + 25'(SteerDownC);
  assign up_step   = 6'(up_prod >> Shift100);
  assign down_step = 6'(down_prod >> Shift100);
  assign steer_o   = steer_up ? (SteerCenter + {2'd0, up_step})
                              : (SteerCenter - {2'd0, down_step});

  // Throttle: idle up to half power, then a linear ramp.
  assign throttle_on = parse_i.power > FieldMid;
  assign p_over      = 6'(parse_i.power - FieldMid);
  assign thr_prod    = 24'(p_over * ThrottleK);
  assign thr_step    = 8'(thr_prod >> Shift10);
  assign throttle_o  = throttle_on ? (ThrottleIdle + thr_step) : ThrottleIdle;

endmodule

[rtl/serial_steer_throttle_decoder.sv]
// Top level of the serial steer/throttle frame decoder.
//
//   channel | signals                                        | direction
//   rx      | rx_valid_i, rx_stall_o, rx_byte_i              | in
//   result  | result_valid_o, result_stall_i, steer/throttle | out
//
// One byte is taken per cycle while rx_stall_o is low; a byte waits in the input register and
// its result, if any, is registered in the output register once the byte is consumed.
// Reset returns to hunting for a newline and drops both registers' valid bits.
// A stalled result holds the sixth field byte in the input register, which in
// turn stalls the rx channel; other bytes keep flowing past a waiting result.
`include "assert_macros.svh"

module serial_steer_throttle_decoder
  import sst_pkg::*;
(
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       rx_valid_i,
  output logic       rx_stall_o,
  input  logic [7:0] rx_byte_i,
  output logic       result_valid_o,
  input  logic       result_stall_i,
  output logic [7:0] steer_compare_o,
  output logic [7:0] throttle_compare_o
);

  logic       in_valid_q, in_valid_d;
  logic [7:0] rx_byte_q;
  logic       out_valid_q, out_valid_d;
  logic [7:0] steer_q;
  logic [7:0] throttle_q;
  logic       out_free;
  logic       consume;
  logic       rx_take;
  parse_t     parse;
  logic [7:0] steer_map;
  logic [7:0] throttle_map;

  // Flow control: a byte that ends a frame waits for room in the output register.
  assign out_free   = !out_valid_q || !result_stall_i;
  assign consume    = in_valid_q && (!parse.emit || out_free);
  assign rx_stall_o = in_valid_q && !consume;
  assign rx_take    = rx_valid_i && !rx_stall_o;

  sst_parser u_parser (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .advance_i (consume),
    .byte_i    (rx_byte_q),
    .parse_o   (parse)
  );

  sst_mapper u_mapper (
    .parse_i    (parse),
    .steer_o    (steer_map),
    .throttle_o (throttle_map)
  );

  // Valid bits of the input and output registers.
  assign in_valid_d  = rx_take || (in_valid_q && !consume);
  assign out_valid_d = (consume && parse.emit) || (out_valid_q && result_stall_i);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      in_valid_q  <= in_valid_d;
      out_valid_q <= out_valid_d;
    end
  end

  // Payload registers.
  always_ff @(posedge clk_i) begin
    if (rx_take) begin
      rx_byte_q <= rx_byte_i;
    end
    if (consume && parse.emit) begin
      steer_q    <= steer_map;
      throttle_q <= throttle_map;
    end
  end

  assign result_valid_o     = out_valid_q;
  assign steer_compare_o    = steer_q;
  assign throttle_compare_o = throttle_q;

  // A new result only appears after a buffered byte was consumed.
  `ASSERT_CLK(a_result_from_byte, $rose(out_valid_q) |-> $past(in_valid_q))
  // Compare values stay within the servo and throttle ranges.
  `ASSERT_CLK(a_steer_range, out_valid_q |-> (steer_q >= 8'd122) && (steer_q <= 8'd177))
  `ASSERT_CLK(a_throttle_range,
              out_valid_q |-> (throttle_q >= 8'd50) && (throttle_q <= 8'd245))
  // A byte held in the input register is not overwritten while it waits.
  `ASSERT_CLK(a_hold_byte, (in_valid_q && !consume) |=> (in_valid_q && $stable(rx_byte_q)))

endmodule
